@@ src/odr_pkg.sv @@
// ----------------------------------------------------------------------------
// odr_pkg: shared types and constants of the overlay descriptor router
// Table sizes, function and action codes, length limits, the queue entry
// passed from front to back and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package odr_pkg;

  // Table sizes (powers of two: the GUID index is the low GUID bits)
  localparam int ROUTE_ENTRIES = 256;
  localparam int OWN_ENTRIES   = 64;
  localparam int PORTS         = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ROUTE_IDX_W = $clog2(ROUTE_ENTRIES);
  localparam int OWN_IDX_W   = $clog2(OWN_ENTRIES);
  localparam int CNT_IDX_W   = $clog2(PORTS);
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TTL       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_LIMIT = 1'd1;

  localparam logic [7:0] MAX_TTL_RESET       = 8'd7;
  localparam logic [7:0] INVALID_LIMIT_RESET = 8'd10;

  // Descriptor function codes
  localparam logic [7:0] FC_PING  = 8'h00;
  localparam logic [7:0] FC_PONG  = 8'h01;
  localparam logic [7:0] FC_PUSH  = 8'h40;
  localparam logic [7:0] FC_QUERY = 8'h80;
  localparam logic [7:0] FC_HITS  = 8'h81;

  // Payload length rules
  localparam logic [31:0] LEN_PONG      = 32'd14;
  localparam logic [31:0] LEN_PUSH      = 32'd26;
  localparam logic [31:0] LEN_QUERY_MAX = 32'd257;
  localparam logic [31:0] LEN_HITS_MAX  = 32'((8 + 256) * 256);
  localparam logic [7:0]  TTL_CEIL      = 8'd50;

  // Result actions
  localparam logic [3:0] ACT_INVALID     = 4'd0;
  localparam logic [3:0] ACT_EXPIRED     = 4'd1;
  localparam logic [3:0] ACT_FORWARD     = 4'd2;
  localparam logic [3:0] ACT_BROADCAST   = 4'd3;
  localparam logic [3:0] ACT_LOCAL_REPLY = 4'd4;
  localparam logic [3:0] ACT_ROUTE_ERR   = 4'd5;
  localparam logic [3:0] ACT_DUPLICATE   = 4'd6;
  localparam logic [3:0] ACT_OWN_LOOP    = 4'd7;
  localparam logic [3:0] ACT_PUSH_LOCAL  = 4'd8;
  localparam logic [3:0] ACT_RECORDED    = 4'd9;

  // What the back end has to do with a queued item
  localparam logic [1:0] OP_DIRECT  = 2'd0;  // result already settled
  localparam logic [1:0] OP_RECORD  = 2'd1;  // write own GUID table
  localparam logic [1:0] OP_REPLY   = 2'd2;  // route and own lookup
  localparam logic [1:0] OP_REQUEST = 2'd3;  // duplicate check and learn

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  action;
    logic [7:0]  ttl;
    logic [7:0]  hop;
    logic        shutdown;
    logic [3:0]  port;
    logic [63:0] guid_hi;
    logic [63:0] guid_lo;
  } odr_item_t;

  typedef struct packed {
    logic [31:0] route_errors;
    logic        shutdown_source;
    logic [7:0]  hop_out;
    logic [7:0]  ttl_out;
    logic [3:0]  dest_port;
    logic [3:0]  action;
  } odr_result_t;

endpackage

`default_nettype wire

@@ src/overlay_descriptor_router.sv @@
// ----------------------------------------------------------------------------
// overlay_descriptor_router: descriptor header routing for an overlay network
// Checks, ages and routes descriptor headers through direct-mapped GUID
// tables, and records the GUIDs this node sends itself.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per beat: s_tuser is the kind (0 received header,
//   1 record own GUID), s_tdata the header fields. m_* returns exactly one
//   result beat per item, in order. cfg_we/cfg_index/cfg_data write
//   max_ttl (index 0) and invalid_limit (index 1); write only while idle.
// Path: items settled by the front (invalid, expired, push, record) pass
//   through the queue slot and the result register; items that look up
//   the GUID tables (replies and requests) also pass the registered table read.
// Throughput: one settled item per cycle while results are taken; a table
//   item holds the back end through the registered read of the route and
//   own tables followed by the compare and write-back.
// Reset (rst, synchronous): clears route and own valid bits, per-port
//   invalid counters, the route error total and the queue; restores
//   max_ttl 7 and invalid_limit 10. No clearing pass is needed.
// Stall: a held result register stops the back end; the two-entry queue
//   keeps taking beats until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module overlay_descriptor_router import odr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input channel
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [7:0] function_code, [39:8] payload_length, [47:40] ttl_in,
  // [55:48] hop_in, [119:56] guid_high, [183:120] guid_low,
  // [187:184] source_port, [191:188] zero
  input  logic [191:0]         s_tdata,
  // [0] kind
  input  logic                 s_tuser,
  // Result channel
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [3:0] action, [7:4] dest_port, [15:8] ttl_out, [23:16] hop_out,
  // [24] shutdown_source, [56:25] route_errors, [63:57] zero
  output logic [63:0]          m_tdata,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0]  max_ttl;
  logic [7:0]  invalid_limit;
  logic        q_push;
  logic        q_ready;
  logic        q_valid;
  logic        q_pop;
  odr_item_t   q_item;
  odr_item_t   q_head;
  odr_result_t res;

  // Configuration registers: take a write whenever cfg_we is high
  always_ff @(posedge clk) begin
    if (rst) begin
      max_ttl       <= MAX_TTL_RESET;
      invalid_limit <= INVALID_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_TTL:       max_ttl       <= cfg_data;
        REG_INVALID_LIMIT: invalid_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: classify each beat and push it straight into the queue
  odr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .kind           (s_tuser),
    .function_code  (s_tdata[7:0]),
    .payload_length (s_tdata[39:8]),
    .ttl_in         (s_tdata[47:40]),
    .hop_in         (s_tdata[55:48]),
    .guid_high      (s_tdata[119:56]),
    .guid_low       (s_tdata[183:120]),
    .source_port    (s_tdata[187:184]),
    .max_ttl        (max_ttl),
    .invalid_limit  (invalid_limit),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  // Queue: decouple header checks from table access
  odr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop       (q_pop),
    .head      (q_head)
  );

  // Back: table lookups, learning and the result register
  odr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack the result beat, action in the low bits
  assign m_tdata = {7'd0, res.route_errors, res.shutdown_source, res.hop_out,
                    res.ttl_out, res.dest_port, res.action};

endmodule

`default_nettype wire

@@ src/odr_front.sv @@
// ----------------------------------------------------------------------------
// odr_front: header checks and classification
// Checks payload length, counts unknown codes per port, ages the TTL and hop
// count, and queues each item with the work left for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module odr_front import odr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [7:0]        function_code,
  input  logic [31:0]       payload_length,
  input  logic [7:0]        ttl_in,
  input  logic [7:0]        hop_in,
  input  logic [63:0]       guid_high,
  input  logic [63:0]       guid_low,
  input  logic [3:0]        source_port,
  input  logic [7:0]        max_ttl,
  input  logic [7:0]        invalid_limit,
  input  logic              q_ready,
  output logic              q_push,
  output odr_item_t         q_item
);

  logic [7:0]           invalid_count [PORTS];
  logic [CNT_IDX_W-1:0] cnt_idx;
  logic [7:0]           cnt;
  logic                 port_ok;
  logic                 known;
  logic                 len_ok;
  logic [8:0]           hop_inc;
  logic [7:0]           ttl_dec;
  logic [7:0]           ttl_clamp;
  logic [7:0]           ttl_adj;
  logic                 expired;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;
  assign cnt_idx  = CNT_IDX_W'(source_port);
  assign port_ok  = 32'(source_port) < 32'(PORTS);
  assign cnt      = invalid_count[cnt_idx];

  always_comb begin
    known  = 1'b1;
    len_ok = 1'b0;
    case (function_code)
      FC_PING:  len_ok = (payload_length == 32'd0);
      FC_PONG:  len_ok = (payload_length == LEN_PONG);
      FC_PUSH:  len_ok = (payload_length == LEN_PUSH);
      FC_QUERY: len_ok = (payload_length <= LEN_QUERY_MAX);
      FC_HITS:  len_ok = (payload_length <= LEN_HITS_MAX);
      default:  known  = 1'b0;
    endcase
  end

  // Aging: hop grows in 9 bits so 255 rolls past any limit
  always_comb begin
    hop_inc   = {1'b0, hop_in} + 9'd1;
    ttl_dec   = ttl_in - 8'd1;
    expired   = (ttl_in <= 8'd1) || (hop_inc > {1'b0, max_ttl}) || (ttl_dec > TTL_CEIL);
    ttl_clamp = (ttl_dec > max_ttl) ? max_ttl : ttl_dec;
    ttl_adj   = (({2'b00, ttl_clamp} + {1'b0, hop_inc}) > {2'b00, max_ttl}) ?
                (max_ttl - hop_inc[7:0]) : ttl_clamp;
  end

  always_comb begin
    q_item          = '0;
    q_item.op       = OP_DIRECT;
    q_item.action   = ACT_INVALID;
    q_item.port     = source_port;
    q_item.guid_hi  = guid_high;
    q_item.guid_lo  = guid_low;
    if (kind) begin
      q_item.op     = OP_RECORD;
      q_item.action = ACT_RECORDED;
    end else if (!known) begin
      q_item.shutdown = port_ok && (cnt > invalid_limit);
    end else if (!len_ok) begin
      q_item.action = ACT_INVALID;
    end else if (expired) begin
      q_item.action = ACT_EXPIRED;
    end else begin
      q_item.ttl = ttl_adj;
      q_item.hop = hop_inc[7:0];
      if (function_code[0]) begin
        q_item.op = OP_REPLY;
      end else if (function_code == FC_PUSH) begin
        q_item.action = ACT_PUSH_LOCAL;
      end else begin
        q_item.op = OP_REQUEST;
      end
    end
  end

  // Saturating per-port count of unknown codes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORTS; i++) begin
        invalid_count[i] <= 8'd0;
      end
    end else if (q_push && !kind && !known && port_ok && (cnt != 8'hFF)) begin
      invalid_count[cnt_idx] <= cnt + 8'd1;
    end
  end

endmodule

`default_nettype wire

@@ src/odr_queue.sv @@
// ----------------------------------------------------------------------------
// odr_queue: short FIFO between front and back
// Holds classified items so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module odr_queue import odr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  odr_item_t  push_item,
  output logic       ready,
  output logic       valid,
  input  logic       pop,
  output odr_item_t  head
);

  odr_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign ready = count < QCNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/odr_back.sv @@
// ----------------------------------------------------------------------------
// odr_back: GUID tables and result register
// Pops queued items, looks up the route and own tables, learns new routes,
// records own GUIDs, counts route errors and holds the result for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module odr_back import odr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  odr_item_t   q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output odr_result_t out_res
);

  localparam int ROUTE_W = 4 + 128;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_LOOK = 1'b1;

  logic                   state;
  logic                   state_next;
  odr_item_t              work;
  logic [ROUTE_W-1:0]     route_mem [ROUTE_ENTRIES];
  logic [127:0]           own_mem [OWN_ENTRIES];
  logic [ROUTE_W-1:0]     route_rd;
  logic [127:0]           own_rd;
  logic [ROUTE_ENTRIES-1:0] route_valid;
  logic [OWN_ENTRIES-1:0]   own_valid;
  logic [31:0]            error_total;
  logic [31:0]            error_total_next;
  logic [31:0]            error_inc;

  logic                   slot_free;
  logic [ROUTE_IDX_W-1:0] head_ri;
  logic [OWN_IDX_W-1:0]   head_oi;
  logic [ROUTE_IDX_W-1:0] work_ri;
  logic [OWN_IDX_W-1:0]   work_oi;
  logic [ROUTE_IDX_W-1:0] route_rd_addr;
  logic [OWN_IDX_W-1:0]   own_rd_addr;
  logic                   rhit;
  logic                   ohit;
  logic                   route_we;
  logic                   own_we;
  logic                   out_load;
  odr_result_t            res_next;

  assign slot_free     = !out_valid || out_ready;
  assign head_ri       = q_head.guid_lo[ROUTE_IDX_W-1:0];
  assign head_oi       = q_head.guid_lo[OWN_IDX_W-1:0];
  assign work_ri       = work.guid_lo[ROUTE_IDX_W-1:0];
  assign work_oi       = work.guid_lo[OWN_IDX_W-1:0];
  // Hold the read address on the item under lookup while it waits
  assign route_rd_addr = (state == B_IDLE) ? head_ri : work_ri;
  assign own_rd_addr   = (state == B_IDLE) ? head_oi : work_oi;
  assign q_pop         = (state == B_IDLE) && q_valid && slot_free;
  assign error_inc     = (error_total != 32'hFFFF_FFFF) ? error_total + 32'd1 : error_total;

  assign rhit = route_valid[work_ri] && (route_rd[127:0] == {work.guid_hi, work.guid_lo});
  assign ohit = own_valid[work_oi] && (own_rd == {work.guid_hi, work.guid_lo});

  always_comb begin
    state_next       = state;
    error_total_next = error_total;
    route_we         = 1'b0;
    own_we           = 1'b0;
    out_load         = 1'b0;
    res_next         = '0;
    case (state)
      B_IDLE: begin
        if (q_pop) begin
          if (q_head.op == OP_DIRECT || q_head.op == OP_RECORD) begin
            out_load                 = 1'b1;
            own_we                   = (q_head.op == OP_RECORD);
            res_next.action          = q_head.action;
            res_next.ttl_out         = q_head.ttl;
            res_next.hop_out         = q_head.hop;
            res_next.shutdown_source = q_head.shutdown;
          end else begin
            state_next = B_LOOK;
          end
        end
      end
      B_LOOK: begin
        if (slot_free) begin
          out_load         = 1'b1;
          state_next       = B_IDLE;
          res_next.ttl_out = work.ttl;
          res_next.hop_out = work.hop;
          if (work.op == OP_REPLY) begin
            if (rhit) begin
              res_next.action    = ACT_FORWARD;
              res_next.dest_port = route_rd[ROUTE_W-1:128];
            end else if (ohit) begin
              res_next.action = ACT_LOCAL_REPLY;
            end else begin
              res_next.action  = ACT_ROUTE_ERR;
              error_total_next = error_inc;
            end
          end else begin
            if (rhit) begin
              res_next.action = ACT_DUPLICATE;
            end else if (ohit) begin
              res_next.action = ACT_OWN_LOOP;
            end else begin
              res_next.action    = ACT_BROADCAST;
              res_next.dest_port = work.port;
              route_we           = 1'b1;
            end
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
    res_next.route_errors = error_total_next;
  end

  // Table storage: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[work_ri] <= {work.port, work.guid_hi, work.guid_lo};
    end
    route_rd <= route_mem[route_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[head_oi] <= {q_head.guid_hi, q_head.guid_lo};
    end
    own_rd <= own_mem[own_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_head;
    end
    if (out_load) begin
      out_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      route_valid <= '0;
      own_valid   <= '0;
      error_total <= 32'd0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      error_total <= error_total_next;
      if (route_we) begin
        route_valid[work_ri] <= 1'b1;
      end
      if (own_we) begin
        own_valid[head_oi] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_learned_valid: assert property (@(posedge clk) disable iff (rst)
    route_we |=> route_valid[$past(work_ri)])
    else $error("learned route entry not marked valid");

  a_errors_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> error_total >= $past(error_total))
    else $error("route error total went down");

  a_errors_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (error_total != $past(error_total)) |->
      out_valid && (out_res.action == ACT_ROUTE_ERR))
    else $error("route error counted without a route error result");

  a_lookup_slot_empty: assert property (@(posedge clk) disable iff (rst)
    (state == B_LOOK) |-> !out_valid)
    else $error("lookup in progress while result register is occupied");
`endif

endmodule

`default_nettype wire
